// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the histogram checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("histogram check failed");

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram check failed");

`endif

// ===== hdl/hfill_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram fill package
// Shared widths, reset values, status codes and a helper function.
// ----------------------------------------------------------------------------
package hfill_pkg;

   localparam int MAX_BINS_DEF    = 64;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int CNT_W    = 32;
   localparam int BIN_W    = 6;
   localparam int STATUS_W = 3;
   localparam int WIDTH_W  = 31;
   localparam int NBINS_W  = 7;
   localparam int EDGE_W   = 32;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic signed [EDGE_W-1:0] LOW_EDGE_RST  = '0;
   localparam logic [WIDTH_W-1:0]       BIN_WIDTH_RST = 31'd65536;
   localparam logic [NBINS_W-1:0]       BIN_COUNT_RST = 7'd64;

   localparam logic [STATUS_W-1:0] STATUS_IN_BIN    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ON_EDGE   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_READBACK  = 3'd4;

   typedef enum logic [1:0] {
      CSR_LOW_EDGE,
      CSR_BIN_WIDTH,
      CSR_BIN_COUNT
   } csr_index_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + CNT_W'(1);
   endfunction

endpackage

// ===== hdl/hfill_div_cell.sv =====
// ----------------------------------------------------------------------------
// Histogram divide cell
// One restoring divide step: compares the remainder with the shifted width,
// subtracts on a hit and appends one quotient bit, then hands on the word.
// ----------------------------------------------------------------------------
module hfill_div_cell #(
   parameter int RW    = 38,
   parameter int QB    = 7,
   parameter int SHIFT = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [RW-1:0]                    in_rem,
   input  logic [QB-1:0]                    in_quo,
   input  logic [hfill_pkg::WIDTH_W-1:0]    divisor,
   output logic                             out_valid,
   output logic [RW-1:0]                    out_rem,
   output logic [QB-1:0]                    out_quo
);

   logic          valid_ff;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] rem_in;
   logic [QB-1:0] quo_ff;
   logic [QB-1:0] quo_in;
   logic [RW-1:0] dsh;
   logic          hit;

   assign dsh    = RW'(divisor) << SHIFT;
   assign hit    = (in_rem >= dsh);
   assign rem_in = hit ? (in_rem - dsh) : in_rem;
   assign quo_in = (in_quo << 1) | QB'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;

endmodule

// ===== hdl/hfill_div_chain.sv =====
// ----------------------------------------------------------------------------
// Histogram divide chain
// A row of divide cells, one quotient bit per cell, most significant first.
// ----------------------------------------------------------------------------
module hfill_div_chain #(
   parameter int RW = 38,
   parameter int QB = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [RW-1:0]                    dividend,
   input  logic [hfill_pkg::WIDTH_W-1:0]    divisor,
   output logic                             done,
   output logic [QB-1:0]                    quo,
   output logic [RW-1:0]                    rem
);

   logic          valid_w [0:QB];
   logic [RW-1:0] rem_w   [0:QB];
   logic [QB-1:0] quo_w   [0:QB];

   assign valid_w[0] = start;
   assign rem_w[0]   = dividend;
   assign quo_w[0]   = '0;

   for (genvar i = 0; i < QB; i++) begin : g_cell
      hfill_div_cell #(
         .RW    (RW),
         .QB    (QB),
         .SHIFT (QB - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_rem    (rem_w[i]),
         .in_quo    (quo_w[i]),
         .divisor   (divisor),
         .out_valid (valid_w[i+1]),
         .out_rem   (rem_w[i+1]),
         .out_quo   (quo_w[i+1])
      );
   end

   assign done = valid_w[QB];
   assign quo  = quo_w[QB];
   assign rem  = rem_w[QB];

endmodule

// ===== hdl/uniform_histogram_fill_top.sv =====
// ----------------------------------------------------------------------------
// Uniform histogram fill, top level
// Equal-width histogram with underflow and overflow tallies.
//
// A word on the req channel either fills (func 0) with a signed sample or
// reads back the count of one bin (func 1). Each request gives exactly one
// word on the rsp channel with status, bin, bin count after the step and
// both running tallies. Every count saturates at its maximum. Settings must
// be written through the csr port while the block is idle; it does not check.
//
// One request is handled at a time. A fill that lands in a bin passes a
// divide chain of $clog2(MAX_BINS+1) cells (ST_DIV), a read of the count
// memory (ST_CLASS) and its write-back with the response (ST_READ); the
// next request is taken once the block is back in ST_IDLE. An underflow, and
// an overflow too large for the divide chain, answer from ST_PRE, a readback
// from ST_READ, and a fill on a bin edge or a near overflow from ST_CLASS.
//
// After reset the count memory is cleared, one entry per cycle, over all
// MAX_BINS entries; req_ready stays low meanwhile. A response that is not
// taken holds its word; the block then finishes the next request up to its
// response and waits there.
// ----------------------------------------------------------------------------
module uniform_histogram_fill_top #(
   parameter int MAX_BINS    = hfill_pkg::MAX_BINS_DEF,
   parameter int SAMPLE_BITS = hfill_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic [hfill_pkg::BIN_W-1:0]         req_bin_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hfill_pkg::STATUS_W-1:0]      rsp_status,
   output logic [hfill_pkg::BIN_W-1:0]         rsp_bin,
   output logic [hfill_pkg::CNT_W-1:0]         rsp_count,
   output logic [hfill_pkg::CNT_W-1:0]         rsp_underflow_total,
   output logic [hfill_pkg::CNT_W-1:0]         rsp_overflow_total,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hfill_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [hfill_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [hfill_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                                csr_pready
);

   localparam int QB = $clog2(MAX_BINS + 1);
   localparam int RW = hfill_pkg::WIDTH_W + QB;
   localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int DW = ((SAMPLE_BITS > hfill_pkg::EDGE_W) ? SAMPLE_BITS
                                                          : hfill_pkg::EDGE_W) + 1;
   localparam int UW = DW - 1;
   localparam int CW = (UW > RW) ? UW : RW;
   localparam int NW = (QB > hfill_pkg::NBINS_W) ? QB : hfill_pkg::NBINS_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRE,
      ST_DIV,
      ST_CLASS,
      ST_READ
   } state_type;

   state_type                            state_ff;
   logic [AW-1:0]                        clr_ff;
   logic                                 func_ff;
   logic [hfill_pkg::BIN_W-1:0]          idx_ff;
   logic signed [DW-1:0]                 d_ff;
   logic signed [DW-1:0]                 d_in;
   logic [AW-1:0]                        addr_ff;
   logic [hfill_pkg::BIN_W-1:0]          bin_ff;
   logic [hfill_pkg::CNT_W-1:0]          below_ff;
   logic [hfill_pkg::CNT_W-1:0]          above_ff;
   logic                                 rsp_valid_ff;
   logic [hfill_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [hfill_pkg::BIN_W-1:0]          rsp_bin_ff;
   logic [hfill_pkg::CNT_W-1:0]          rsp_count_ff;
   logic                                 rsp_set;

   logic signed [hfill_pkg::EDGE_W-1:0]  low_edge_ff;
   logic [hfill_pkg::WIDTH_W-1:0]        bin_width_ff;
   logic [hfill_pkg::NBINS_W-1:0]        bin_count_ff;
   hfill_pkg::csr_index_type             csr_index;
   logic                                 csr_wr;

   logic [hfill_pkg::WIDTH_W-1:0]        w_eff;
   logic [NW-1:0]                        n_raw;
   logic [NW-1:0]                        n_eff;
   logic                                 d_neg;
   logic [CW-1:0]                        ud_c;
   logic [CW-1:0]                        lim_c;
   logic                                 pre_over;
   logic                                 in_rng;
   logic                                 out_free;

   logic                                 div_start;
   logic                                 div_done;
   logic [QB-1:0]                        div_quo;
   logic [RW-1:0]                        div_rem;
   logic [NW-1:0]                        quo_n;
   logic                                 cls_over;
   logic                                 cls_edge;

   logic [hfill_pkg::CNT_W-1:0]          mem [0:MAX_BINS-1];
   logic [hfill_pkg::CNT_W-1:0]          rd_data_ff;
   logic                                 mem_we;
   logic [AW-1:0]                        mem_waddr;
   logic [hfill_pkg::CNT_W-1:0]          mem_wdata;
   logic                                 mem_re;
   logic [AW-1:0]                        mem_raddr;

   // Configuration registers.
   assign csr_index  = hfill_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_edge_ff  <= hfill_pkg::LOW_EDGE_RST;
         bin_width_ff <= hfill_pkg::BIN_WIDTH_RST;
         bin_count_ff <= hfill_pkg::BIN_COUNT_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            hfill_pkg::CSR_LOW_EDGE:  low_edge_ff  <= csr_pwdata;
            hfill_pkg::CSR_BIN_WIDTH: bin_width_ff <= csr_pwdata[hfill_pkg::WIDTH_W-1:0];
            hfill_pkg::CSR_BIN_COUNT: bin_count_ff <= csr_pwdata[hfill_pkg::NBINS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         hfill_pkg::CSR_LOW_EDGE:  csr_prdata = low_edge_ff;
         hfill_pkg::CSR_BIN_WIDTH: csr_prdata = hfill_pkg::CSR_DW'(bin_width_ff);
         hfill_pkg::CSR_BIN_COUNT: csr_prdata = hfill_pkg::CSR_DW'(bin_count_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // Effective settings and range tests.
   assign w_eff = (bin_width_ff == '0) ? hfill_pkg::WIDTH_W'(1) : bin_width_ff;
   assign n_raw = NW'(bin_count_ff);
   assign n_eff = (n_raw == '0)           ? NW'(1) :
                  (n_raw > NW'(MAX_BINS)) ? NW'(MAX_BINS) : n_raw;

   assign d_in     = DW'(req_sample) - DW'(low_edge_ff);
   assign d_neg    = d_ff[DW-1];
   assign ud_c     = CW'(d_ff[UW-1:0]);
   assign lim_c    = CW'(RW'(w_eff) << QB);
   assign pre_over = (ud_c >= lim_c);
   assign in_rng   = (32'(idx_ff) < 32'(MAX_BINS));
   assign out_free = !rsp_valid_ff || rsp_ready;

   hfill_div_chain #(
      .RW (RW),
      .QB (QB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (RW'(ud_c)),
      .divisor  (w_eff),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   assign quo_n    = NW'(div_quo);
   assign cls_over = (quo_n > n_eff) || ((quo_n == n_eff) && (div_rem != '0));
   assign cls_edge = (div_rem == '0);

   always_comb begin
      div_start = 1'b0;
      rsp_set   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = hfill_pkg::sat_inc(rd_data_ff);
      mem_re    = 1'b0;
      mem_raddr = AW'(div_quo);
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         ST_PRE: begin
            if (func_ff) begin
               mem_re    = in_rng;
               mem_raddr = AW'(idx_ff);
            end else if (d_neg || pre_over) begin
               rsp_set = out_free;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_CLASS: begin
            mem_re  = !cls_over && !cls_edge;
            rsp_set = out_free && (cls_over || cls_edge);
         end
         ST_READ: begin
            mem_we  = !func_ff && out_free;
            rsp_set = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         below_ff     <= '0;
         above_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_set || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff  <= req_func;
                  idx_ff   <= req_bin_index;
                  d_ff     <= d_in;
                  state_ff <= ST_PRE;
               end
            end
            ST_PRE: begin
               if (func_ff) begin
                  bin_ff   <= idx_ff;
                  state_ff <= ST_READ;
               end else if (d_neg) begin
                  if (out_free) begin
                     below_ff      <= hfill_pkg::sat_inc(below_ff);
                     rsp_status_ff <= hfill_pkg::STATUS_UNDERFLOW;
                     rsp_bin_ff    <= '0;
                     rsp_count_ff  <= '0;
                     state_ff      <= ST_IDLE;
                  end
               end else if (pre_over) begin
                  if (out_free) begin
                     above_ff      <= hfill_pkg::sat_inc(above_ff);
                     rsp_status_ff <= hfill_pkg::STATUS_OVERFLOW;
                     rsp_bin_ff    <= '0;
                     rsp_count_ff  <= '0;
                     state_ff      <= ST_IDLE;
                  end
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_CLASS;
               end
            end
            ST_CLASS: begin
               if (cls_over) begin
                  if (out_free) begin
                     above_ff      <= hfill_pkg::sat_inc(above_ff);
                     rsp_status_ff <= hfill_pkg::STATUS_OVERFLOW;
                     rsp_bin_ff    <= '0;
                     rsp_count_ff  <= '0;
                     state_ff      <= ST_IDLE;
                  end
               end else if (cls_edge) begin
                  if (out_free) begin
                     rsp_status_ff <= hfill_pkg::STATUS_ON_EDGE;
                     rsp_bin_ff    <= '0;
                     rsp_count_ff  <= '0;
                     state_ff      <= ST_IDLE;
                  end
               end else begin
                  addr_ff  <= AW'(div_quo);
                  bin_ff   <= hfill_pkg::BIN_W'(div_quo);
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (out_free) begin
                  rsp_bin_ff   <= bin_ff;
                  if (func_ff) begin
                     rsp_status_ff <= hfill_pkg::STATUS_READBACK;
                     rsp_count_ff  <= in_rng ? rd_data_ff : '0;
                  end else begin
                     rsp_status_ff <= hfill_pkg::STATUS_IN_BIN;
                     rsp_count_ff  <= hfill_pkg::sat_inc(rd_data_ff);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_bin             = rsp_bin_ff;
   assign rsp_count           = rsp_count_ff;
   assign rsp_underflow_total = below_ff;
   assign rsp_overflow_total  = above_ff;

endmodule

// ===== hdl/hfill_checker.sv =====
// ----------------------------------------------------------------------------
// Histogram fill checker
// Port-level checks on the request and response channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfill_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [hfill_pkg::STATUS_W-1:0]    rsp_status,
   input logic [hfill_pkg::BIN_W-1:0]       rsp_bin,
   input logic [hfill_pkg::CNT_W-1:0]       rsp_count
);

   logic rsp_stall;
   logic miss_word;
   logic fill_word;
   logic req_take;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign miss_word = rsp_valid && (rsp_status == hfill_pkg::STATUS_UNDERFLOW ||
                                    rsp_status == hfill_pkg::STATUS_OVERFLOW ||
                                    rsp_status == hfill_pkg::STATUS_ON_EDGE);
   assign fill_word = rsp_valid && (rsp_status == hfill_pkg::STATUS_IN_BIN);
   assign req_take  = req_valid && req_ready;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_count))
   `CHK_IMPLY(a_miss_zero, clock, reset, miss_word, rsp_bin == '0 && rsp_count == '0)
   `CHK_IMPLY(a_fill_nonzero, clock, reset, fill_word, rsp_count != '0)
   `CHK_NEXT(a_one_at_a_time, clock, reset, req_take, !req_ready)
   `CHK_ALWAYS(a_status_range, clock, reset, !rsp_valid || rsp_status <= hfill_pkg::STATUS_READBACK)

endmodule

bind uniform_histogram_fill_top hfill_checker u_hfill_checker (.*);

// ===== dv/tb_uniform_histogram_fill_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Uniform histogram fill testbench
// Drives fill and readback words into the histogram under a range of bin
// settings, with random gaps on both sides. A scoreboard keeps its own copy
// of the bin counts and the underflow and overflow tallies, predicts every
// response word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_uniform_histogram_fill_top;

   localparam logic OP_FILL = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct {
      logic [hfill_pkg::STATUS_W-1:0] status;
      logic [hfill_pkg::BIN_W-1:0]    bin;
      logic [hfill_pkg::CNT_W-1:0]    count;
      logic [hfill_pkg::CNT_W-1:0]    under;
      logic [hfill_pkg::CNT_W-1:0]    over;
   } hist_word_type;

   class hist_scoreboard;
      logic signed [hfill_pkg::EDGE_W-1:0] low_edge;
      logic [hfill_pkg::WIDTH_W-1:0]       bin_width;
      logic [hfill_pkg::NBINS_W-1:0]       bin_limit;
      logic [hfill_pkg::CNT_W-1:0]         bin_tally [hfill_pkg::MAX_BINS_DEF];
      logic [hfill_pkg::CNT_W-1:0]         below_tally;
      logic [hfill_pkg::CNT_W-1:0]         above_tally;
      hist_word_type                       pending [$];
      int unsigned                         errors;
      int unsigned                         checked;
      int unsigned                         status_seen [8];

      function new();
         foreach (bin_tally[i]) bin_tally[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
         below_tally = '0;
         above_tally = '0;
         low_edge = hfill_pkg::LOW_EDGE_RST;
         bin_width = hfill_pkg::BIN_WIDTH_RST;
         bin_limit = hfill_pkg::BIN_COUNT_RST;
         errors = 0;
         checked = 0;
      endfunction

      function longint width_used();
         return (bin_width == 0) ? 64'd1 : longint'(bin_width);
      endfunction

      function longint bins_used();
         if (bin_limit == 0) return longint'(1);
         if (bin_limit > hfill_pkg::MAX_BINS_DEF) return longint'(hfill_pkg::MAX_BINS_DEF);
         return longint'(bin_limit);
      endfunction

      function void note_request(logic func, logic signed [31:0] smp,
                                 logic [hfill_pkg::BIN_W-1:0] idx);
         hist_word_type     r;
         longint            d;
         longint unsigned   ud;
         longint unsigned   w;
         longint unsigned   top;
         longint unsigned   q;
         r.bin = '0;
         r.count = '0;
         if (func == OP_READ) begin
            r.status = hfill_pkg::STATUS_READBACK;
            r.bin = idx;
            r.count = bin_tally[idx];
         end else begin
            d = longint'(smp) - longint'(low_edge);
            w = width_used();
            top = bins_used() * w;
            ud = d;
            if (d < 0) begin
               if (below_tally != '1) below_tally += 1;
               r.status = hfill_pkg::STATUS_UNDERFLOW;
            end else if (ud > top) begin
               if (above_tally != '1) above_tally += 1;
               r.status = hfill_pkg::STATUS_OVERFLOW;
            end else if (ud == top || ud % w == 0) begin
               r.status = hfill_pkg::STATUS_ON_EDGE;
            end else begin
               q = ud / w;
               if (bin_tally[q] != '1) bin_tally[q] += 1;
               r.status = hfill_pkg::STATUS_IN_BIN;
               r.bin = q[hfill_pkg::BIN_W-1:0];
               r.count = bin_tally[q];
            end
         end
         r.under = below_tally;
         r.over = above_tally;
         pending.insert(pending.size(), r);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         errors++;
      endfunction

      function void check_result(hist_word_type got);
         hist_word_type want;
         if (pending.size() == 0) begin
            $display("%0t: response word with nothing expected, status %0d bin %0d",
                     $time, got.status, got.bin);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         status_seen[want.status]++;
         if (got.status !== want.status) report("status", 32'(want.status), 32'(got.status));
         if (got.bin !== want.bin) report("bin", 32'(want.bin), 32'(got.bin));
         if (got.count !== want.count) report("count", want.count, got.count);
         if (got.under !== want.under) report("underflow_total", want.under, got.under);
         if (got.over !== want.over) report("overflow_total", want.over, got.over);
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_func = OP_FILL;
   logic signed [31:0]                req_sample = '0;
   logic [hfill_pkg::BIN_W-1:0]       req_bin_index = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [hfill_pkg::STATUS_W-1:0]    rsp_status;
   logic [hfill_pkg::BIN_W-1:0]       rsp_bin;
   logic [hfill_pkg::CNT_W-1:0]       rsp_count;
   logic [hfill_pkg::CNT_W-1:0]       rsp_underflow_total;
   logic [hfill_pkg::CNT_W-1:0]       rsp_overflow_total;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [hfill_pkg::CSR_AW-1:0]      csr_paddr = '0;
   logic [hfill_pkg::CSR_DW-1:0]      csr_pwdata = '0;
   logic [hfill_pkg::CSR_DW-1:0]      csr_prdata;
   logic                              csr_pready;

   hist_scoreboard sb;
   bit             pace_on = 1'b1;
   int unsigned    setting_count = 0;

   uniform_histogram_fill_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_sample          (req_sample),
      .req_bin_index       (req_bin_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_bin             (rsp_bin),
      .rsp_count           (rsp_count),
      .rsp_underflow_total (rsp_underflow_total),
      .rsp_overflow_total  (rsp_overflow_total),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= pace_on ? ($urandom_range(99) >= 13) : 1'b1;
   end

   always @(posedge clock) begin
      hist_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = rsp_status;
         got.bin = rsp_bin;
         got.count = rsp_count;
         got.under = rsp_underflow_total;
         got.over = rsp_overflow_total;
         sb.check_result(got);
      end
   end

   task automatic send_word(input logic func, input logic signed [31:0] smp,
                            input logic [hfill_pkg::BIN_W-1:0] idx);
      if (pace_on) begin
         while ($urandom_range(99) < 13) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_sample <= smp;
      req_bin_index <= idx;
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, smp, idx);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_setting(input hfill_pkg::csr_index_type which,
                                input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] got;
      mask = (which == hfill_pkg::CSR_BIN_WIDTH) ? 32'h7FFF_FFFF :
             (which == hfill_pkg::CSR_BIN_COUNT) ? 32'h0000_007F : 32'hFFFF_FFFF;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= hfill_pkg::CSR_AW'(4 * int'(which));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== (value & mask)) begin
         $display("%0t: register %s readback mismatch, expected %0h, got %0h",
                  $time, which.name(), value & mask, got);
         sb.errors++;
      end
      case (which)
         hfill_pkg::CSR_LOW_EDGE: sb.low_edge = value;
         hfill_pkg::CSR_BIN_WIDTH: sb.bin_width = value[hfill_pkg::WIDTH_W-1:0];
         default: sb.bin_limit = value[hfill_pkg::NBINS_W-1:0];
      endcase
   endtask

   task automatic apply_settings(input logic [31:0] lo, input logic [31:0] w,
                                 input logic [31:0] n);
      drain();
      write_setting(hfill_pkg::CSR_LOW_EDGE, lo);
      write_setting(hfill_pkg::CSR_BIN_WIDTH, w);
      write_setting(hfill_pkg::CSR_BIN_COUNT, n);
      setting_count++;
   endtask

   task automatic send_random;
      logic                        func;
      logic signed [31:0]          smp;
      logic [hfill_pkg::BIN_W-1:0] idx;
      longint                      w;
      longint                      n;
      longint                      lo;
      longint                      v;
      int unsigned                 pick;
      w = sb.width_used();
      n = sb.bins_used();
      lo = longint'(sb.low_edge);
      pick = $urandom_range(99);
      func = (pick < 25) ? OP_READ : OP_FILL;
      idx = hfill_pkg::BIN_W'($urandom);
      smp = $urandom;
      v = 64'sh7FFF_FFFF_FFFF_FFFF;
      if (pick >= 25 && pick < 65) begin
         v = lo + longint'($urandom_range(32'(n - 1))) * w;
         if ($urandom_range(9) != 0) v += longint'($urandom_range(32'(w - 1)));
      end else if (pick >= 65 && pick < 80) begin
         v = lo - 1 - longint'($urandom_range(2000));
      end else if (pick >= 80 && pick < 90) begin
         v = lo + n * w + longint'($urandom_range(2000));
      end
      if (v >= -64'sd2147483648 && v <= 64'sd2147483647) smp = v[31:0];
      send_word(func, smp, idx);
   endtask

   task automatic random_phase(input int items, input bit calm, input bit hold);
      pace_on = !calm;
      for (int i = 0; i < items; i++) begin
         if (hold && i == items / 2) begin
            req_valid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
         send_random();
      end
      pace_on = 1'b1;
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_READ, '0, 6'd0);
      send_word(OP_READ, '0, 6'd63);
      send_word(OP_FILL, 40 * 65536 + 5, '0);
      send_word(OP_FILL, 0, '0);
      send_word(OP_FILL, -1, '0);
      send_word(OP_FILL, 64 * 65536, '0);
      send_word(OP_FILL, 64 * 65536 + 1, '0);

      apply_settings(-1000, 100, 8);
      send_word(OP_FILL, 32'sh8000_0000, '0);
      send_word(OP_FILL, 32'sh7FFF_FFFF, '0);
      send_word(OP_FILL, -1001, '0);
      send_word(OP_FILL, -1000, '0);
      send_word(OP_FILL, -999, '0);
      send_word(OP_FILL, -901, '0);
      send_word(OP_FILL, -900, '0);
      send_word(OP_FILL, -550, '0);
      send_word(OP_FILL, -201, '0);
      send_word(OP_FILL, -200, '0);
      send_word(OP_FILL, -199, '0);
      send_word(OP_READ, '0, 6'd0);
      send_word(OP_READ, '0, 6'd4);
      send_word(OP_READ, '0, 6'd40);
      send_word(OP_READ, '0, 6'd63);

      apply_settings(0, 65536, 64);
      random_phase(200, 1'b0, 1'b0);
      apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 64);
      random_phase(180, 1'b0, 1'b0);
      apply_settings(32'h7FFF_FFFF, 0, 0);
      random_phase(120, 1'b0, 1'b0);
      apply_settings(-37, 3, 127);
      random_phase(220, 1'b0, 1'b1);
      apply_settings(123456, 1000, 1);
      random_phase(150, 1'b0, 1'b0);
      apply_settings(-5000, 77, 40);
      random_phase(280, 1'b1, 1'b0);

      drain();
      $display("Checked %0d response words under %0d bin settings.", sb.checked, setting_count);
      $display("In bin %0d, underflow %0d, overflow %0d, on an edge %0d, readback %0d.",
               sb.status_seen[hfill_pkg::STATUS_IN_BIN],
               sb.status_seen[hfill_pkg::STATUS_UNDERFLOW],
               sb.status_seen[hfill_pkg::STATUS_OVERFLOW],
               sb.status_seen[hfill_pkg::STATUS_ON_EDGE],
               sb.status_seen[hfill_pkg::STATUS_READBACK]);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timed out with %0d response words outstanding.", sb.pending.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== uniform_histogram_fill_top.f =====
+incdir+hdl
hdl/hfill_pkg.sv
hdl/hfill_div_cell.sv
hdl/hfill_div_chain.sv
hdl/uniform_histogram_fill_top.sv
hdl/hfill_checker.sv
dv/tb_uniform_histogram_fill_top.sv
